FILE: sv/mnl_pkg.sv
// Shared types, constants and key-layout functions for the MIDI note LED mapper.
package mnl_pkg;

    localparam int LED_COUNT_DEF = 144;
    localparam int GAP_GROUP_DEF = 3;

    localparam int NOTE_LOW  = 21;
    localparam int NOTE_HIGH = 108;
    localparam int NOTE_SPAN = NOTE_HIGH - NOTE_LOW;
    localparam int NOTE_KEYS = NOTE_SPAN + 1;
    localparam int KEY_W     = 7;
    localparam int HUE_MAX   = 255;

    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

    // floor(x / 127) == (x * RECIP_127) >> RECIP_SHIFT for x < 2**16
    localparam int          PROD_W      = 16;
    localparam int          SCALED_W    = 33;
    localparam logic [16:0] RECIP_127   = 17'd66053;
    localparam int          RECIP_SHIFT = 23;
    localparam int          QUOT_W      = SCALED_W - RECIP_SHIFT;
    localparam logic [7:0]  LEVEL_MAX   = 8'hFF;

    localparam int         CFG_DATA_W     = 32;
    localparam int         CFG_ADDR_W     = 3;
    localparam int         CFG_IDX_W      = CFG_ADDR_W - 2;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'b0;
    localparam logic [7:0] BRIGHT_RESET   = 8'hFF;

    localparam int EVQ_DEPTH  = 2;
    localparam int OUTQ_DEPTH = 2;

    typedef struct packed {
        logic [7:0]        led_start;
        logic              second;
        logic [7:0]        hue;
        logic [PROD_W-1:0] prod;
    } note_event_t;

    typedef struct packed {
        logic [7:0] led_index;
        logic [7:0] hue;
        logic [7:0] level;
        logic       last_write;
    } led_write_t;

    function automatic bit key_is_white(int note);
        int pc;
        pc = note % 12;
        return (pc == 0) || (pc == 2) || (pc == 4) || (pc == 5) ||
               (pc == 7) || (pc == 9) || (pc == 11);
    endfunction

    // elaboration only: start LED of key k (note NOTE_LOW + k)
    function automatic int key_start(int k, int gap_group, int led_count);
        int idx;
        int grp;
        idx = 0;
        grp = 0;
        for (int n = 0; n < k; n++) begin
            idx += key_is_white(NOTE_LOW + n) ? 2 : 1;
            grp++;
            if (grp == gap_group) begin
                grp = 0;
                idx += 1;
            end
            if (idx >= led_count) begin
                idx = led_count - 1;
            end
        end
        return idx;
    endfunction

    function automatic int note_hue(int k);
        return (k * HUE_MAX) / NOTE_SPAN;
    endfunction

endpackage

FILE: sv/mnl_fifo.sv
// Small register FIFO used for the event queue and the result queue.
module mnl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end
endmodule

FILE: sv/mnl_front.sv
// Front end: packet filter, transfer-skip tracking and note event build.
module mnl_front #(
    parameter int LED_COUNT = mnl_pkg::LED_COUNT_DEF,
    parameter int GAP_GROUP = mnl_pkg::GAP_GROUP_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           header_byte,
    input  logic [7:0]           status_byte,
    input  logic [7:0]           note_byte,
    input  logic [7:0]           velocity_byte,
    input  logic                 transfer_ok,
    input  logic                 end_of_transfer,
    input  logic [7:0]           brightness,
    output logic                 ev_push,
    output mnl_pkg::note_event_t ev_data,
    input  logic                 ev_full
);
    import mnl_pkg::*;

    logic [7:0] start_tab  [NOTE_KEYS];
    logic       second_tab [NOTE_KEYS];
    logic [7:0] hue_tab    [NOTE_KEYS];

    for (genvar k = 0; k < NOTE_KEYS; k++)
    begin : g_key
        localparam int START = key_start(k, GAP_GROUP, LED_COUNT);
        assign start_tab[k]  = 8'(START);
        assign second_tab[k] = key_is_white(NOTE_LOW + k) && (START + 1 < LED_COUNT);
        assign hue_tab[k]    = 8'(note_hue(k));
    end

    logic             skip_reg, skip_next;
    logic             accept, live, all_zero, is_note, in_range, note_on;
    logic [3:0]       kind;
    logic [7:0]       note_ofs;
    logic [KEY_W-1:0] key;

    assign full     = ev_full;
    assign accept   = push && !ev_full;
    assign live     = transfer_ok && !skip_reg;
    assign all_zero = (header_byte == 8'd0) && (status_byte == 8'd0) &&
                      (note_byte == 8'd0) && (velocity_byte == 8'd0);
    assign kind     = status_byte[7:4];
    assign is_note  = (kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON);
    assign in_range = (note_byte >= 8'(NOTE_LOW)) && (note_byte <= 8'(NOTE_HIGH));
    assign note_on  = (kind == KIND_NOTE_ON) && (velocity_byte != 8'd0);
    assign note_ofs = note_byte - 8'(NOTE_LOW);
    assign key      = note_ofs[KEY_W-1:0];

    assign ev_push = accept && live && !all_zero && is_note && in_range;

    always_comb
    begin
        ev_data.led_start = start_tab[key];
        ev_data.second    = second_tab[key];
        ev_data.hue       = note_on ? hue_tab[key] : 8'd0;
        ev_data.prod      = note_on ? PROD_W'(velocity_byte) * PROD_W'(brightness)
                                    : '0;
    end

    always_comb
    begin
        skip_next = skip_reg;
        if (accept)
        begin
            priority if (!live)
            begin
                if (end_of_transfer)
                begin
                    skip_next = 1'b0;
                end
            end
            else if (all_zero)
            begin
                skip_next = !end_of_transfer;
            end
            else if (end_of_transfer)
            begin
                skip_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= 1'b0;
        end
        else
        begin
            skip_reg <= skip_next;
        end
    end
endmodule

FILE: sv/mnl_back.sv
// Back end: level scaling and expansion of each event into one or two LED writes.
module mnl_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ev_empty,
    input  mnl_pkg::note_event_t ev_data,
    output logic                 ev_pop,
    input  logic                 wr_full,
    output logic                 wr_push,
    output mnl_pkg::led_write_t  wr_data
);
    import mnl_pkg::*;

    logic                hold_valid_reg, hold_valid_next;
    note_event_t         hold_ev_reg;
    logic                phase_reg, phase_next;
    logic [SCALED_W-1:0] scaled_reg;
    logic [QUOT_W-1:0]   quot;
    logic                cur_last, wr_fire, done;

    assign cur_last = phase_reg || !hold_ev_reg.second;
    assign wr_fire  = hold_valid_reg && !wr_full;
    assign done     = wr_fire && cur_last;
    assign ev_pop   = !ev_empty && (!hold_valid_reg || done);
    assign wr_push  = wr_fire;
    assign quot     = scaled_reg[SCALED_W-1:RECIP_SHIFT];

    always_comb
    begin
        wr_data.led_index  = phase_reg ? hold_ev_reg.led_start + 8'd1 : hold_ev_reg.led_start;
        wr_data.hue        = hold_ev_reg.hue;
        wr_data.level      = (quot > QUOT_W'(LEVEL_MAX)) ? LEVEL_MAX : quot[7:0];
        wr_data.last_write = cur_last;
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        phase_next      = phase_reg;
        priority if (ev_pop)
        begin
            hold_valid_next = 1'b1;
            phase_next      = 1'b0;
        end
        else if (done)
        begin
            hold_valid_next = 1'b0;
        end
        else if (wr_fire)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_pop)
        begin
            hold_ev_reg <= ev_data;
            scaled_reg  <= SCALED_W'(ev_data.prod) * SCALED_W'(RECIP_127);
        end
    end
endmodule

FILE: sv/midi_note_led_strip_mapper_top.sv
// Top level of the MIDI note to LED strip mapper.
//
// Input queue: drive one USB-MIDI packet on the packet ports and raise push;
// the transaction is taken on a clock edge with push high and full low.
// Result queue: while empty is low the oldest LED write is on led_index, hue,
// level and last_write; it is taken on a clock edge with pop high.
// A white key yields two writes unless it starts on the last LED, a black key
// one; last_write marks the final write of an event. Filtered packets yield none.
// A write passes through the event queue, the sequencer hold register and the
// result queue; the second write of a white key follows the first.
// Throughput: one packet per cycle while full is low, into a two-entry event
// queue; the write sequencer drains one LED write per cycle while the result
// queue has room.
// A stalled result queue backs up the sequencer, then the event queue, and
// finally raises full; nothing is dropped.
// Reset clears both queues and the transfer-skip flag and sets brightness to
// 255. Brightness is written over the APB port at byte address 0.
module midi_note_led_strip_mapper_top #(
    parameter int LED_COUNT = mnl_pkg::LED_COUNT_DEF,
    parameter int GAP_GROUP = mnl_pkg::GAP_GROUP_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mnl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mnl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mnl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     header_byte,
    input  logic [7:0]                     status_byte,
    input  logic [7:0]                     note_byte,
    input  logic [7:0]                     velocity_byte,
    input  logic                           transfer_ok,
    input  logic                           end_of_transfer,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     led_index,
    output logic [7:0]                     hue,
    output logic [7:0]                     level,
    output logic                           last_write
);
    import mnl_pkg::*;

    localparam int EV_W = $bits(note_event_t);
    localparam int WR_W = $bits(led_write_t);

    logic [7:0]           brightness_reg, brightness_next;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        brightness_next = brightness_reg;
        if (cfg_wr && (reg_idx == REG_BRIGHTNESS))
        begin
            brightness_next = pwdata[7:0];
        end
        prdata = '0;
        if (reg_idx == REG_BRIGHTNESS)
        begin
            prdata = CFG_DATA_W'(brightness_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRIGHT_RESET;
        end
        else
        begin
            brightness_reg <= brightness_next;
        end
    end

    logic        ev_push, ev_full, ev_pop, ev_empty;
    note_event_t ev_wdata, ev_rdata;
    logic [EV_W-1:0] ev_rbits;
    logic        wr_push, wr_full;
    led_write_t  wr_wdata, wr_rdata;
    logic [WR_W-1:0] wr_rbits;

    mnl_front #(
        .LED_COUNT(LED_COUNT),
        .GAP_GROUP(GAP_GROUP)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .header_byte    (header_byte),
        .status_byte    (status_byte),
        .note_byte      (note_byte),
        .velocity_byte  (velocity_byte),
        .transfer_ok    (transfer_ok),
        .end_of_transfer(end_of_transfer),
        .brightness     (brightness_reg),
        .ev_push        (ev_push),
        .ev_data        (ev_wdata),
        .ev_full        (ev_full)
    );

    mnl_fifo #(
        .WIDTH(EV_W),
        .DEPTH(EVQ_DEPTH)
    ) u_evq (
        .clk  (clk),
        .rst_n(rst_n),
        .push (ev_push),
        .wdata(ev_wdata),
        .full (ev_full),
        .pop  (ev_pop),
        .rdata(ev_rbits),
        .empty(ev_empty)
    );

    assign ev_rdata = note_event_t'(ev_rbits);

    mnl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .ev_empty(ev_empty),
        .ev_data (ev_rdata),
        .ev_pop  (ev_pop),
        .wr_full (wr_full),
        .wr_push (wr_push),
        .wr_data (wr_wdata)
    );

    mnl_fifo #(
        .WIDTH(WR_W),
        .DEPTH(OUTQ_DEPTH)
    ) u_outq (
        .clk  (clk),
        .rst_n(rst_n),
        .push (wr_push),
        .wdata(wr_wdata),
        .full (wr_full),
        .pop  (pop),
        .rdata(wr_rbits),
        .empty(empty)
    );

    assign wr_rdata   = led_write_t'(wr_rbits);
    assign led_index  = wr_rdata.led_index;
    assign hue        = wr_rdata.hue;
    assign level      = wr_rdata.level;
    assign last_write = wr_rdata.last_write;
endmodule

FILE: sv/mnl_checker.sv
// Port-level assertions for the MIDI note LED mapper, bound to the top level.
module mnl_checker #(
    parameter int LED_COUNT = mnl_pkg::LED_COUNT_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [mnl_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [mnl_pkg::CFG_DATA_W-1:0] pwdata,
    input logic [mnl_pkg::CFG_DATA_W-1:0] prdata,
    input logic                           pready,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input logic [7:0]                     led_index,
    input logic [7:0]                     hue,
    input logic [7:0]                     level,
    input logic                           last_write
);
    import mnl_pkg::*;

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (LED_COUNT <= 256)) |-> (32'(led_index) < 32'(LED_COUNT)))
        else $error("led_index beyond strip");

    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[CFG_ADDR_W-1:2] == REG_BRIGHTNESS))
        |=> ((paddr[CFG_ADDR_W-1:2] != REG_BRIGHTNESS) ||
             (prdata == CFG_DATA_W'($past(pwdata[7:0])))))
        else $error("brightness readback mismatch");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(led_index) && $stable(level) &&
                              $stable(hue) && $stable(last_write)))
        else $error("stalled result changed");
endmodule

bind midi_note_led_strip_mapper_top mnl_checker #(.LED_COUNT(LED_COUNT)) u_checker (.*);

FILE: tb/sv/midi_note_led_strip_mapper_top_test.sv
// Self-checking testbench for the MIDI note to LED strip mapper.
`timescale 1ns / 1ps

module midi_note_led_strip_mapper_top_test;
    import mnl_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int VEL_FULL      = 127;
    localparam int PACKETS_PER_PHASE = 88;
    localparam logic [11:0] WHITE_MASK = 12'b1010_1011_0101;
    localparam logic [CFG_ADDR_W-1:0] ADDR_BRIGHTNESS =
        CFG_ADDR_W'({REG_BRIGHTNESS, 2'b00});

    typedef struct packed {
        logic [7:0] hdr;
        logic [7:0] status;
        logic [7:0] note;
        logic [7:0] vel;
        logic       ok;
        logic       eot;
    } midi_packet_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push = 1'b0;
    logic                  full;
    logic [7:0]            header_byte = '0;
    logic [7:0]            status_byte = '0;
    logic [7:0]            note_byte = '0;
    logic [7:0]            velocity_byte = '0;
    logic                  transfer_ok = 1'b0;
    logic                  end_of_transfer = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [7:0]            led_index;
    logic [7:0]            hue;
    logic [7:0]            level;
    logic                  last_write;

    midi_note_led_strip_mapper_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .header_byte     (header_byte),
        .status_byte     (status_byte),
        .note_byte       (note_byte),
        .velocity_byte   (velocity_byte),
        .transfer_ok     (transfer_ok),
        .end_of_transfer (end_of_transfer),
        .empty           (empty),
        .pop             (pop),
        .led_index       (led_index),
        .hue             (hue),
        .level           (level),
        .last_write      (last_write)
    );

    led_write_t pending_writes[$];
    int         key_led_start[0:255];
    logic [7:0] brightness_cfg = BRIGHT_RESET;
    bit         skip_rest = 1'b0;

    int fail_count = 0;
    int packets_sent = 0;
    int note_events = 0;
    int writes_checked = 0;
    int full_stalls = 0;
    int settings_used = 0;
    int burst_left = 0;

    int cycle_count = 0;
    int hold_request = 0;
    int hold_left = 0;
    int pop_mode = 0;
    int mode_age = 0;
    led_write_t want;

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: check each transaction, then pick the next pop value
    always @(posedge clk) begin
        if (pop && !empty) begin
            if (pending_writes.size() == 0) begin
                $error("unexpected LED write: led_index %0d hue %0d level %0d last_write %0b",
                       led_index, hue, level, last_write);
                fail_count++;
            end else begin
                want = pending_writes.pop_front();
                writes_checked++;
                if (led_index !== want.led_index) begin
                    $error("led_index expected %0d actual %0d", want.led_index, led_index);
                    fail_count++;
                end
                if (hue !== want.hue) begin
                    $error("hue expected %0d actual %0d", want.hue, hue);
                    fail_count++;
                end
                if (level !== want.level) begin
                    $error("level expected %0d actual %0d", want.level, level);
                    fail_count++;
                end
                if (last_write !== want.last_write) begin
                    $error("last_write expected %0b actual %0b", want.last_write, last_write);
                    fail_count++;
                end
            end
        end
        mode_age++;
        if (mode_age >= 48) begin
            mode_age = 0;
            pop_mode = $urandom_range(0, 3);
        end
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (!rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            case (pop_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= (mode_age % 3 == 0);
                default: pop <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    function automatic bit is_white(int note);
        return WHITE_MASK[note % 12];
    endfunction

    function automatic void build_key_table();
        int idx;
        int grp;
        idx = 0;
        grp = 0;
        for (int n = 0; n < 256; n++) begin
            key_led_start[n] = 0;
        end
        for (int n = NOTE_LOW; n <= NOTE_HIGH; n++) begin
            key_led_start[n] = idx;
            idx += is_white(n) ? 2 : 1;
            grp++;
            if (grp == GAP_GROUP_DEF) begin
                grp = 0;
                idx++;
            end
            if (idx >= LED_COUNT_DEF) begin
                idx = LED_COUNT_DEF - 1;
            end
        end
    endfunction

    // queues the LED writes one packet causes; returns how many
    function automatic int predict_led_writes(midi_packet_t p);
        led_write_t w;
        logic [3:0] kind;
        int         note;
        int         start;
        int         hue_v;
        int         lvl;
        bit         two;
        note = int'(p.note);
        if (!p.ok || skip_rest) begin
            if (p.eot) begin
                skip_rest = 1'b0;
            end
            return 0;
        end
        if (p.hdr == 8'd0 && p.status == 8'd0 && p.note == 8'd0 && p.vel == 8'd0) begin
            skip_rest = !p.eot;
            return 0;
        end
        if (p.eot) begin
            skip_rest = 1'b0;
        end
        kind = p.status[7:4];
        if (kind != KIND_NOTE_OFF && kind != KIND_NOTE_ON) begin
            return 0;
        end
        if (note < NOTE_LOW || note > NOTE_HIGH) begin
            return 0;
        end
        hue_v = 0;
        lvl = 0;
        if (kind == KIND_NOTE_ON && p.vel != 8'd0) begin
            hue_v = (note - NOTE_LOW) * HUE_MAX / (NOTE_HIGH - NOTE_LOW);
            lvl = int'(p.vel) * int'(brightness_cfg) / VEL_FULL;
            if (lvl > int'(LEVEL_MAX)) begin
                lvl = int'(LEVEL_MAX);
            end
        end
        start = key_led_start[note];
        two = is_white(note) && (start + 1 < LED_COUNT_DEF);
        w.led_index = start[7:0];
        w.hue = hue_v[7:0];
        w.level = lvl[7:0];
        w.last_write = !two;
        pending_writes.push_back(w);
        if (two) begin
            w.led_index = 8'(start + 1);
            w.last_write = 1'b1;
            pending_writes.push_back(w);
            return 2;
        end
        return 1;
    endfunction

    function automatic midi_packet_t note_pkt(logic [7:0] status, logic [7:0] note,
                                              logic [7:0] vel);
        midi_packet_t p;
        p.hdr = {4'h0, status[7:4]};
        p.status = status;
        p.note = note;
        p.vel = vel;
        p.ok = 1'b1;
        p.eot = 1'b1;
        return p;
    endfunction

    function automatic midi_packet_t random_packet();
        midi_packet_t p;
        int pick;
        pick = $urandom_range(0, 99);
        p.hdr = 8'($urandom);
        p.ok = ($urandom_range(0, 19) != 0);
        p.eot = ($urandom_range(0, 3) == 0);
        p.vel = 8'($urandom_range(1, VEL_FULL));
        if ($urandom_range(0, 9) == 0) begin
            p.vel = ($urandom_range(0, 1) == 1) ? 8'd0 : 8'($urandom_range(128, 255));
        end
        p.status = {($urandom_range(0, 1) == 1) ? KIND_NOTE_ON : KIND_NOTE_OFF,
                    4'($urandom)};
        p.note = 8'($urandom_range(NOTE_LOW, NOTE_HIGH));
        if (pick >= 70 && pick < 78) begin
            p.hdr = 8'd0;
            p.status = 8'd0;
            p.note = 8'd0;
            p.vel = 8'd0;
        end else if (pick >= 78 && pick < 85) begin
            p.note = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, NOTE_LOW - 1))
                                                  : 8'($urandom_range(NOTE_HIGH + 1, 255));
        end else if (pick >= 85) begin
            p = midi_packet_t'({$urandom, 2'($urandom)});
        end
        return p;
    endfunction

    task automatic send_packet(midi_packet_t p);
        header_byte <= p.hdr;
        status_byte <= p.status;
        note_byte <= p.note;
        velocity_byte <= p.vel;
        transfer_ok <= p.ok;
        end_of_transfer <= p.eot;
        push <= 1'b1;
        @(posedge clk);
        while (full) begin
            full_stalls++;
            @(posedge clk);
        end
        packets_sent++;
        if (predict_led_writes(p) > 0) begin
            note_events++;
        end
    endtask

    // bursts of back-to-back transactions separated by random gaps
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_writes.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_brightness(logic [7:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_BRIGHTNESS;
        pwdata <= CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        brightness_cfg = value;
        settings_used++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[7:0] !== value) begin
            $error("brightness readback expected %0d actual %0d", value, prdata[7:0]);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_note_extremes();
        send_packet(note_pkt({KIND_NOTE_ON, 4'h0}, 8'(NOTE_LOW), 8'd127));
        send_packet(note_pkt({KIND_NOTE_ON, 4'h3}, 8'(NOTE_HIGH), 8'd127));
        send_packet(note_pkt({KIND_NOTE_ON, 4'h0}, 8'd22, 8'd1));
        send_packet(note_pkt({KIND_NOTE_ON, 4'h0}, 8'd60, 8'd255));
        send_packet(note_pkt({KIND_NOTE_ON, 4'h0}, 8'd60, 8'd0));
        send_packet(note_pkt({KIND_NOTE_OFF, 4'h0}, 8'(NOTE_LOW), 8'd64));
        send_packet(note_pkt({KIND_NOTE_ON, 4'h0}, 8'(NOTE_LOW - 1), 8'd100));
        send_packet(note_pkt({KIND_NOTE_ON, 4'h0}, 8'(NOTE_HIGH + 1), 8'd100));
        drain();
    endtask

    task automatic test_status_filter();
        send_packet(note_pkt(8'hA5, 8'd60, 8'd90));
        send_packet(note_pkt(8'hF0, 8'd61, 8'd90));
        send_packet(note_pkt(8'h7F, 8'd62, 8'd90));
        send_packet(note_pkt({KIND_NOTE_OFF, 4'hF}, 8'd64, 8'd90));
        send_packet(note_pkt({KIND_NOTE_ON, 4'hF}, 8'd107, 8'd90));
        drain();
    endtask

    task automatic test_transfer_skip();
        midi_packet_t p;
        p = note_pkt({KIND_NOTE_ON, 4'h0}, 8'd60, 8'd80);
        p.ok = 1'b0;
        send_packet(p);
        p = '0;
        p.ok = 1'b1;
        send_packet(p);
        p = note_pkt({KIND_NOTE_ON, 4'h0}, 8'd60, 8'd80);
        p.eot = 1'b0;
        send_packet(p);
        send_packet(note_pkt({KIND_NOTE_ON, 4'h0}, 8'd61, 8'd80));
        send_packet(note_pkt({KIND_NOTE_ON, 4'h0}, 8'd62, 8'd80));
        p = '0;
        p.ok = 1'b1;
        p.eot = 1'b1;
        send_packet(p);
        send_packet(note_pkt({KIND_NOTE_ON, 4'h0}, 8'd63, 8'd80));
        drain();
    endtask

    task automatic test_brightness_extremes();
        write_brightness(8'd0);
        send_packet(note_pkt({KIND_NOTE_ON, 4'h0}, 8'd69, 8'd127));
        send_packet(note_pkt({KIND_NOTE_ON, 4'h0}, 8'd70, 8'd255));
        write_brightness(8'd200);
        send_packet(note_pkt({KIND_NOTE_ON, 4'h0}, 8'd71, 8'd127));
        send_packet(note_pkt({KIND_NOTE_ON, 4'h0}, 8'd72, 8'd255));
        drain();
    endtask

    // receiver stalls long enough for the input side to report full
    task automatic test_backpressure();
        hold_request = 80;
        for (int i = 0; i < 24; i++) begin
            send_packet(note_pkt({KIND_NOTE_ON, 4'($urandom)},
                                 8'($urandom_range(NOTE_LOW, NOTE_HIGH)),
                                 8'($urandom_range(1, 127))));
        end
        drain();
    endtask

    task automatic test_random_traffic();
        logic [7:0] setting;
        int         target;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1: setting = 8'd1;
                3: setting = 8'd255;
                default: setting = 8'($urandom_range(2, 254));
            endcase
            write_brightness(setting);
            burst_left = 0;
            target = packets_sent + PACKETS_PER_PHASE;
            while (packets_sent < target) begin
                send_packet(random_packet());
                pace_sender();
            end
            drain();
        end
    endtask

    initial begin
        build_key_table();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_note_extremes();
        test_status_filter();
        test_transfer_skip();
        test_brightness_extremes();
        test_backpressure();
        test_random_traffic();
        drain();
        $display("covered %0d packets, %0d note events, %0d LED writes checked",
                 packets_sent, note_events, writes_checked);
        $display("used %0d brightness settings; input held off by full for %0d cycles",
                 settings_used, full_stalls);
        if (fail_count == 0 && pending_writes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
